// ===== design/tcspa_pkg.sv =====
package tcspa_pkg;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FAIL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam int MAX_SERVERS = 256;
	localparam int ID_W        = $clog2(MAX_SERVERS);
	localparam int COUNT_W     = $clog2(MAX_SERVERS + 1);

	typedef struct packed {
		logic       accept;
		logic       rd_head;
		logic       unlink;
		logic       free_w1;
		logic       free_w2;
		logic       res_set;
		logic [1:0] res_status;
		logic       load;
	} dp_cmd_t;

	typedef struct packed {
		logic invalid;
		logic mode_free;
		logic busy;
		logic heads_nil;
		logic clearing;
	} dp_stat_t;

endpackage

// ===== design/tcspa_if.sv =====
interface tcspa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [tcspa_pkg::ID_W-1:0]    server_id;
	logic                          want_class;

	modport source (output valid, mode, server_id, want_class, input ready);
	modport sink   (input valid, mode, server_id, want_class, output ready);
endinterface

interface tcspa_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     status;
	logic [tcspa_pkg::ID_W-1:0]     assigned_id;
	logic [tcspa_pkg::COUNT_W-1:0]  class0_count;
	logic [tcspa_pkg::COUNT_W-1:0]  class1_count;

	modport source (output valid, status, assigned_id, class0_count, class1_count,
		input ready);
	modport sink   (input valid, status, assigned_id, class0_count, class1_count,
		output ready);
endinterface

// ===== design/tcspa_ctrl.sv =====
module tcspa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  tcspa_pkg::dp_stat_t stat,
	output tcspa_pkg::dp_cmd_t  cmd
);
	import tcspa_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHK   = 3'd1;
	localparam logic [2:0] S_HEAD  = 3'd2;
	localparam logic [2:0] S_FREE2 = 3'd3;
	localparam logic [2:0] S_RESP  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       acc;

	assign req_ready = (state_q == S_IDLE) && !stat.clearing;
	assign acc       = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.accept = acc;
		case (state_q)
			S_IDLE: begin
				if (acc) state_d = S_CHK;
			end
			S_CHK: begin
				state_d = S_RESP;
				cmd.res_set = 1'b1;
				if (stat.invalid) begin
					cmd.res_status = ST_INVALID;
				end else if (stat.mode_free) begin
					if (stat.busy) begin
						cmd.free_w1 = 1'b1;
						cmd.res_status = ST_OK;
						state_d = S_FREE2;
					end else begin
						cmd.res_status = ST_FAIL;
					end
				end else if (!stat.busy) begin
					cmd.unlink = 1'b1;
					cmd.res_status = ST_OK;
				end else if (stat.heads_nil) begin
					cmd.res_status = ST_FAIL;
				end else begin
					cmd.rd_head = 1'b1;
					cmd.res_status = ST_OK;
					state_d = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.unlink = 1'b1;
				state_d = S_RESP;
			end
			S_FREE2: begin
				cmd.free_w2 = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == S_CHK) else $error("accepted word did not start");
	a_head_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_head |-> stat.busy && !stat.heads_nil) else $error("bad head read");
	a_load_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !rsp_ready |-> !cmd.load) else $error("result overwritten");

endmodule

// ===== design/tcspa_dp.sv =====
module tcspa_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tcspa_pkg::dp_cmd_t                 cmd,
	output tcspa_pkg::dp_stat_t                stat,
	input  logic                               cfg_we,
	input  logic [tcspa_pkg::COUNT_W-1:0]      cfg_data,
	input  logic                               in_mode,
	input  logic [tcspa_pkg::ID_W-1:0]         in_id,
	input  logic                               in_want,
	output logic [1:0]                         out_status,
	output logic [tcspa_pkg::ID_W-1:0]         out_assigned,
	output logic [tcspa_pkg::COUNT_W-1:0]      out_c0,
	output logic [tcspa_pkg::COUNT_W-1:0]      out_c1
);
	import tcspa_pkg::*;

	localparam int IW    = $clog2(MAX_SERVERS);
	localparam int LW    = IW + 1;
	localparam int NW    = $clog2(MAX_SERVERS + 1);
	localparam logic [LW-1:0] NIL = LW'(MAX_SERVERS);

	logic [LW-1:0] next_mem [MAX_SERVERS];
	logic [LW-1:0] prev_mem [MAX_SERVERS];
	logic [1:0]    meta_mem [MAX_SERVERS];

	logic [NW-1:0] n_q, cnt0_q, cnt1_q;
	logic [LW-1:0] h0_q, t0_q, h1_q, t1_q;
	logic          mode_q, want_q;
	logic [ID_W-1:0] id_q;
	logic [IW-1:0] vic_q;
	logic [LW-1:0] nxt_rd_q, prv_rd_q;
	logic [1:0]    meta_rd_q, res_q;
	logic          clr_busy_q;
	logic [IW-1:0] clr_idx_q;

	logic [LW-1:0] e_prv, e_nxt, hw, ho, pick, tail_c;
	logic          e_cls, e_busy;
	logic          rd_en;
	logic [IW-1:0] ra, idx;
	logic [NW-1:0] cfg_n;

	function automatic logic nil(input logic [LW-1:0] l);
		return l >= NIL;
	endfunction

	assign idx = IW'(id_q);
	assign rd_en = cmd.accept || cmd.rd_head;
	assign ra    = cmd.accept ? IW'(in_id) : pick[IW-1:0];

	always_comb begin
		if (32'(cfg_data) == 0) cfg_n = NW'(1);
		else if (32'(cfg_data) > MAX_SERVERS) cfg_n = NW'(MAX_SERVERS);
		else cfg_n = NW'(cfg_data);
	end

	always_comb begin
		e_cls  = meta_rd_q[1];
		e_busy = meta_rd_q[0];
		e_prv  = prv_rd_q;
		e_nxt  = nxt_rd_q;
		hw     = want_q ? h1_q : h0_q;
		ho     = want_q ? h0_q : h1_q;
		pick   = nil(hw) ? ho : hw;
		tail_c = e_cls ? t1_q : t0_q;
	end

	assign stat.invalid   = 16'(id_q) >= 16'(n_q);
	assign stat.mode_free = mode_q;
	assign stat.busy      = e_busy;
	assign stat.heads_nil = nil(h0_q) && nil(h1_q);
	assign stat.clearing  = clr_busy_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			nxt_rd_q  <= next_mem[ra];
			prv_rd_q  <= prev_mem[ra];
			meta_rd_q <= meta_mem[ra];
		end
		if (cmd.accept) begin
			mode_q <= in_mode;
			id_q   <= in_id;
			want_q <= in_want;
			vic_q  <= IW'(in_id);
		end else if (cmd.rd_head) begin
			vic_q <= pick[IW-1:0];
		end
		if (cmd.res_set) res_q <= cmd.res_status;
		if (cmd.load) begin
			out_status   <= res_q;
			out_assigned <= (res_q == ST_OK && !mode_q) ? ID_W'(vic_q) : '0;
			out_c0       <= COUNT_W'(cnt0_q);
			out_c1       <= COUNT_W'(cnt1_q);
		end
		// rebuild pass: one entry per cycle, fresh chain in id order
		if (clr_busy_q) begin
			next_mem[clr_idx_q] <= ((LW'(clr_idx_q) + LW'(1)) < LW'(n_q)) ?
				LW'(clr_idx_q) + LW'(1) : NIL;
			prev_mem[clr_idx_q] <= (clr_idx_q == '0) ? NIL : LW'(clr_idx_q) - LW'(1);
			meta_mem[clr_idx_q] <= 2'b00;
		end
		if (cmd.unlink) begin
			if (!nil(e_prv)) next_mem[e_prv[IW-1:0]] <= e_nxt;
			if (!nil(e_nxt)) prev_mem[e_nxt[IW-1:0]] <= e_prv;
			meta_mem[vic_q] <= {want_q, 1'b1};
		end
		if (cmd.free_w1) begin
			prev_mem[idx] <= tail_c;
			next_mem[idx] <= NIL;
			meta_mem[idx] <= {e_cls, 1'b0};
		end
		if (cmd.free_w2 && !nil(tail_c)) next_mem[tail_c[IW-1:0]] <= LW'(idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			n_q    <= NW'(MAX_SERVERS);
			cnt0_q <= NW'(MAX_SERVERS);
			cnt1_q <= '0;
			h0_q <= '0;
			t0_q <= LW'(MAX_SERVERS - 1);
			h1_q <= NIL;
			t1_q <= NIL;
		end else if (cfg_we) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
			n_q    <= cfg_n;
			cnt0_q <= cfg_n;
			cnt1_q <= '0;
			h0_q <= '0;
			t0_q <= LW'(cfg_n) - LW'(1);
			h1_q <= NIL;
			t1_q <= NIL;
		end else begin
			if (clr_busy_q) begin
				clr_idx_q <= clr_idx_q + IW'(1);
				if (clr_idx_q == IW'(MAX_SERVERS - 1)) clr_busy_q <= 1'b0;
			end
			if (cmd.unlink) begin
				if (nil(e_prv)) begin
					if (e_cls) h1_q <= e_nxt;
					else h0_q <= e_nxt;
				end
				if (nil(e_nxt)) begin
					if (e_cls) t1_q <= e_prv;
					else t0_q <= e_prv;
				end
				if (e_cls != want_q) begin
					if (want_q) begin
						cnt1_q <= cnt1_q + NW'(1);
						cnt0_q <= cnt0_q - NW'(1);
					end else begin
						cnt0_q <= cnt0_q + NW'(1);
						cnt1_q <= cnt1_q - NW'(1);
					end
				end
			end
			if (cmd.free_w2) begin
				if (nil(tail_c)) begin
					if (e_cls) h1_q <= LW'(idx);
					else h0_q <= LW'(idx);
				end
				if (e_cls) t1_q <= LW'(idx);
				else t0_q <= LW'(idx);
			end
		end
	end

	a_count_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(NW+1)'(cnt0_q) + (NW+1)'(cnt1_q) == (NW+1)'(n_q)) else $error("class counts drift");
	a_list0_ends: assert property (@(posedge clk) disable iff (!arst_n)
		nil(h0_q) == nil(t0_q)) else $error("class 0 list ends disagree");
	a_list1_ends: assert property (@(posedge clk) disable iff (!arst_n)
		nil(h1_q) == nil(t1_q)) else $error("class 1 list ends disagree");

endmodule

// ===== design/two_class_server_pool_allocator_unit.sv =====
// Each word passes S_CHK and S_RESP, with S_HEAD between them when a request finds
// its preferred server busy and another free, or S_FREE2 when a release succeeds (one more
// dependent link read or write); the result is registered when S_RESP loads it. A new word
// is taken only in S_IDLE, once the last result is loaded; a result held by rsp_ch.ready
// stalls the next word in S_RESP. Reset and server_count writes rebuild the pool, one link
// entry a cycle, with req_ch not ready: every server class 0 and free, chained in id order.
module two_class_server_pool_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	tcspa_req_if.sink                     req_ch,
	tcspa_rsp_if.source                   rsp_ch,
	input  logic                          cfg_we,
	input  logic [tcspa_pkg::COUNT_W-1:0] cfg_data
);
	import tcspa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tcspa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcspa_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.in_mode      (req_ch.mode),
		.in_id        (req_ch.server_id),
		.in_want      (req_ch.want_class),
		.out_status   (rsp_ch.status),
		.out_assigned (rsp_ch.assigned_id),
		.out_c0       (rsp_ch.class0_count),
		.out_c1       (rsp_ch.class1_count)
	);

endmodule

// ===== tb/tb.sv =====
module tb;
	import tcspa_pkg::*;

	localparam int NSRV = MAX_SERVERS;
	localparam int NIL  = NSRV;
	localparam logic MODE_REQ  = 1'b0;
	localparam logic MODE_FREE = 1'b1;

	typedef struct packed {
		logic       mode;
		logic [7:0] server_id;
		logic       want_class;
	} job_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] assigned_id;
		logic [8:0] c0;
		logic [8:0] c1;
	} grant_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [COUNT_W-1:0] cfg_data;

	tcspa_req_if req_ch();
	tcspa_rsp_if rsp_ch();

	two_class_server_pool_allocator_unit DUT (
		.clk(clk), .arst_n(arst_n), .req_ch(req_ch), .rsp_ch(rsp_ch),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// pool shadow
	int pool_n;
	bit pool_cls[NSRV];
	bit pool_busy[NSRV];
	int nxt[NSRV];
	int prv[NSRV];
	int hd[2], tl[2], cnt[2];

	job_t   pending_jobs[$];
	grant_t expected_grants[$];
	int     errors = 0;
	int     gap;
	int     rsp_gap;
	bit     hold;
	longint cycles;

	function automatic void pool_init(int v);
		int n;
		n = v;
		if (n == 0) n = 1;
		if (n > NSRV) n = NSRV;
		pool_n = n;
		for (int i = 0; i < NSRV; i++) begin
			pool_cls[i] = 0;
			pool_busy[i] = 0;
			prv[i] = (i < n && i > 0) ? i - 1 : NIL;
			nxt[i] = (i + 1 < n) ? i + 1 : NIL;
		end
		hd[0] = 0; tl[0] = n - 1; hd[1] = NIL; tl[1] = NIL;
		cnt[0] = n; cnt[1] = 0;
	endfunction

	function automatic void take(int id, int c);
		int o, p, x;
		o = pool_cls[id];
		p = prv[id];
		x = nxt[id];
		if (p < NIL) nxt[p] = x; else hd[o] = x;
		if (x < NIL) prv[x] = p; else tl[o] = p;
		prv[id] = NIL; nxt[id] = NIL;
		pool_busy[id] = 1;
		if (o != c) begin
			pool_cls[id] = c[0];
			cnt[c]++;
			cnt[o]--;
		end
	endfunction

	function automatic grant_t allocate(job_t j);
		grant_t g;
		int id, w, a, t, c;
		id = j.server_id;
		w = j.want_class;
		a = 0;
		g.status = ST_FAIL;
		if (id >= pool_n) begin
			g.status = ST_INVALID;
		end else if (j.mode == MODE_REQ) begin
			if (!pool_busy[id]) begin
				a = id; take(id, w); g.status = ST_OK;
			end else if (hd[w] < NIL) begin
				a = hd[w]; take(a, w); g.status = ST_OK;
			end else if (hd[w ^ 1] < NIL) begin
				a = hd[w ^ 1]; take(a, w); g.status = ST_OK;
			end
		end else if (pool_busy[id]) begin
			pool_busy[id] = 0;
			c = pool_cls[id];
			t = tl[c];
			prv[id] = t; nxt[id] = NIL;
			if (t < NIL) nxt[t] = id; else hd[c] = id;
			tl[c] = id;
			g.status = ST_OK;
		end
		g.assigned_id = (g.status == ST_OK && j.mode == MODE_REQ) ? a[7:0] : 8'd0;
		g.c0 = cnt[0][8:0];
		g.c1 = cnt[1][8:0];
		return g;
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 0;
			req_ch.mode <= 0;
			req_ch.server_id <= 0;
			req_ch.want_class <= 0;
			gap <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_grants.push_back(allocate({req_ch.mode, req_ch.server_id,
					req_ch.want_class}));
				void'(pending_jobs.pop_front());
			end
			if ((req_ch.valid && !req_ch.ready)) begin
			end else if (gap > 0) begin
				req_ch.valid <= 0;
				gap <= gap - 1;
			end else if (hold || pending_jobs.size() == 0) begin
				req_ch.valid <= 0;
			end else begin
				job_t j;
				j = pending_jobs[0];
				req_ch.valid <= 1;
				req_ch.mode <= j.mode;
				req_ch.server_id <= j.server_id;
				req_ch.want_class <= j.want_class;
				gap <= rand_gap();
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 0;
			rsp_gap <= 0;
			cycles <= 0;
		end else begin
			cycles <= cycles + 1;
			if (cycles > 400000) begin
				$display("FAIL");
				$finish;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_grants.size() == 0) begin
					$error("unexpected word");
					errors++;
				end else begin
					grant_t e;
					e = expected_grants.pop_front();
					if (rsp_ch.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp_ch.status);
						errors++;
					end
					if (rsp_ch.assigned_id !== e.assigned_id) begin
						$error("assigned_id exp %0d got %0d", e.assigned_id,
							rsp_ch.assigned_id);
						errors++;
					end
					if (rsp_ch.class0_count !== e.c0) begin
						$error("class0_count exp %0d got %0d", e.c0, rsp_ch.class0_count);
						errors++;
					end
					if (rsp_ch.class1_count !== e.c1) begin
						$error("class1_count exp %0d got %0d", e.c1, rsp_ch.class1_count);
						errors++;
					end
				end
			end
			if (rsp_gap > 0) begin
				rsp_ch.ready <= 0;
				rsp_gap <= rsp_gap - 1;
			end else begin
				rsp_ch.ready <= 1;
				rsp_gap <= rand_gap();
			end
		end
	end

	task automatic add(logic m, int id, logic w);
		job_t j;
		j.mode = m;
		j.server_id = id[7:0];
		j.want_class = w;
		pending_jobs.push_back(j);
	endtask

	task automatic drain();
		while (pending_jobs.size() != 0 || req_ch.valid || expected_grants.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_count(int v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_data <= v[8:0];
		pool_init(v);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// mostly valid traffic: free busy servers, request with random preference
	task automatic random_phase(int items);
		bit busy_sh[NSRV];
		int id;
		for (int i = 0; i < NSRV; i++) busy_sh[i] = 0;
		for (int i = 0; i < items; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				add(1'($urandom_range(0, 1)), $urandom_range(0, 255),
					1'($urandom_range(0, 1)));
			end else begin
				id = $urandom_range(0, pool_n - 1);
				if ($urandom_range(0, 1) && busy_sh[id]) begin
					add(MODE_FREE, id, 1'($urandom_range(0, 1)));
					busy_sh[id] = 0;
				end else begin
					add(MODE_REQ, id, 1'($urandom_range(0, 1)));
					if (!busy_sh[id]) busy_sh[id] = 1;
					else for (int k = 0; k < pool_n; k++) if (busy_sh[k]) busy_sh[k] = 1;
				end
			end
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 4)) begin
					id = $urandom_range(0, pool_n - 1);
					add(MODE_FREE, id, 1'b0);
					busy_sh[id] = 0;
				end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_data = 0;
		hold = 0;
		pool_init(NSRV);
		repeat (3) @(posedge clk);
		arst_n <= 1;

		add(MODE_REQ, 0, 1'b1);
		add(MODE_REQ, 0, 1'b1);
		add(MODE_REQ, 255, 1'b0);
		add(MODE_FREE, 255, 1'b1);
		add(MODE_FREE, 255, 1'b0);
		add(MODE_FREE, 0, 1'b0);
		add(MODE_REQ, 170, 1'b1);
		add(MODE_REQ, 85, 1'b0);
		drain();

		set_count(2);
		add(MODE_REQ, 2, 1'b0);
		add(MODE_REQ, 0, 1'b1);
		add(MODE_REQ, 0, 1'b0);
		add(MODE_REQ, 1, 1'b1);
		add(MODE_FREE, 1, 1'b1);
		add(MODE_FREE, 1, 1'b0);
		add(MODE_REQ, 0, 1'b0);
		add(MODE_FREE, 0, 1'b0);
		drain();

		set_count(0);
		add(MODE_REQ, 0, 1'b1);
		add(MODE_REQ, 0, 1'b0);
		add(MODE_REQ, 1, 1'b0);
		add(MODE_FREE, 0, 1'b0);
		random_phase(30);
		drain();

		set_count(511);
		random_phase(120);
		repeat (20) @(posedge clk);
		hold = 1;
		while (expected_grants.size() != 0 || req_ch.valid) @(posedge clk);
		hold = 0;
		random_phase(40);
		drain();

		set_count($urandom_range(3, 12));
		random_phase(90);
		drain();

		set_count(256);
		random_phase(50);
		drain();

		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
